// ===== sv/fhs_pkg.sv =====
// ----------------------------------------------------------------------------
// fhs_pkg
// Shared types, codes and constants of the job scheduler.
// ----------------------------------------------------------------------------
package fhs_pkg;

	localparam int TIME_BITS       = 16;
	localparam int SLOT_FIELD_BITS = 4;
	localparam int KIND_BITS       = 2;
	localparam int JOB_SLOTS_DEF   = 16;

	localparam logic FUNC_ADD  = 1'b0;
	localparam logic FUNC_TICK = 1'b1;

	localparam logic [KIND_BITS-1:0] RPT_ACCEPTED = 2'd0;
	localparam logic [KIND_BITS-1:0] RPT_FULL     = 2'd1;
	localparam logic [KIND_BITS-1:0] RPT_TICK     = 2'd2;

	typedef logic [TIME_BITS-1:0] stamp_t;

	localparam stamp_t STAMP_MAX = '1;

	typedef struct packed {
		logic   func;
		stamp_t job_arrival;
		stamp_t job_need;
	} job_item_t;

	typedef struct packed {
		logic [KIND_BITS-1:0]       report_kind;
		logic [SLOT_FIELD_BITS-1:0] job_slot;
		logic                       busy_res;
		stamp_t                     now_time;
		logic                       started_now;
		stamp_t                     job_start;
		logic                       job_done;
		stamp_t                     turnaround;
	} report_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_FIND,
		ST_SCAN_RD,
		ST_SCAN_MUL,
		ST_SCAN_CMP,
		ST_EXEC
	} fhs_state_t;

	typedef struct packed {
		logic load_in;
		logic find_step;
		logic add_commit;
		logic add_full;
		logic scan_mul;
		logic scan_cmp;
		logic exec;
	} fhs_cmd_t;

	typedef struct packed {
		logic func;
		logic slot_free;
		logic idx_last;
		logic running;
		logic out_free;
	} fhs_stat_t;

endpackage

// ===== sv/fhs_stream_if.sv =====
// ----------------------------------------------------------------------------
// fhs_stream_if
// Valid/ready channel carrying one item of type T.
// ----------------------------------------------------------------------------
interface fhs_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/fhs_ram.sv =====
// ----------------------------------------------------------------------------
// fhs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fhs_ram #(
	parameter int WIDTH = 2 * fhs_pkg::TIME_BITS,
	parameter int DEPTH = fhs_pkg::JOB_SLOTS_DEF
) (
	input  logic                                        clk,
	input  logic                                        we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                            wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                            rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule

// ===== sv/fhs_ctrl.sv =====
// ----------------------------------------------------------------------------
// fhs_ctrl
// Sequencer: decodes an item, runs the free-slot search or, when no job is running,
// the dispatch scan, then commits the item and loads the result register.
// ----------------------------------------------------------------------------
module fhs_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                job_valid,
	output logic                job_ready,
	input  fhs_pkg::fhs_stat_t  stat,
	output fhs_pkg::fhs_cmd_t   cmd
);
	fhs_pkg::fhs_state_t state_q;
	fhs_pkg::fhs_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fhs_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			fhs_pkg::ST_IDLE: begin
				if (job_valid) state_d = fhs_pkg::ST_DECODE;
			end
			fhs_pkg::ST_DECODE: begin
				if (stat.func == fhs_pkg::FUNC_ADD) state_d = fhs_pkg::ST_FIND;
				else if (stat.running)              state_d = fhs_pkg::ST_EXEC;
				else                                state_d = fhs_pkg::ST_SCAN_RD;
			end
			fhs_pkg::ST_FIND: begin
				if (stat.out_free && (stat.slot_free || stat.idx_last)) begin
					state_d = fhs_pkg::ST_IDLE;
				end
			end
			fhs_pkg::ST_SCAN_RD:  state_d = fhs_pkg::ST_SCAN_MUL;
			fhs_pkg::ST_SCAN_MUL: state_d = fhs_pkg::ST_SCAN_CMP;
			fhs_pkg::ST_SCAN_CMP: begin
				state_d = stat.idx_last ? fhs_pkg::ST_EXEC : fhs_pkg::ST_SCAN_MUL;
			end
			fhs_pkg::ST_EXEC: begin
				if (stat.out_free) state_d = fhs_pkg::ST_IDLE;
			end
			default: state_d = fhs_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd       = '0;
		job_ready = 1'b0;
		unique case (state_q) inside
			fhs_pkg::ST_IDLE: begin
				job_ready   = 1'b1;
				cmd.load_in = job_valid;
			end
			fhs_pkg::ST_FIND: begin
				cmd.add_commit = stat.out_free && stat.slot_free;
				cmd.add_full   = stat.out_free && !stat.slot_free && stat.idx_last;
				cmd.find_step  = !stat.slot_free && !stat.idx_last;
			end
			fhs_pkg::ST_SCAN_MUL: cmd.scan_mul = 1'b1;
			fhs_pkg::ST_SCAN_CMP: cmd.scan_cmp = 1'b1;
			fhs_pkg::ST_EXEC:     cmd.exec     = stat.out_free;
			fhs_pkg::ST_DECODE, fhs_pkg::ST_SCAN_RD: begin
				cmd = '0;
			end
			default: cmd = '0;
		endcase
	end

	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load_in, cmd.find_step, cmd.add_commit, cmd.add_full,
			cmd.scan_mul, cmd.scan_cmp, cmd.exec}))
		else $error("fhs_ctrl: more than one command at once");

	a_mul_order: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan_mul |-> ($past(state_q) == fhs_pkg::ST_SCAN_RD
			|| $past(state_q) == fhs_pkg::ST_SCAN_CMP))
		else $error("fhs_ctrl: scan multiply step out of order");
endmodule

// ===== sv/fhs_dpath.sv =====
// ----------------------------------------------------------------------------
// fhs_dpath
// Job table, clock, running job, dispatch compare unit and result register.
// ----------------------------------------------------------------------------
module fhs_dpath #(
	parameter int JOB_SLOTS = fhs_pkg::JOB_SLOTS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  fhs_pkg::fhs_cmd_t     cmd,
	output fhs_pkg::fhs_stat_t    stat,
	input  logic                  cfg_wr_en,
	input  logic                  cfg_wr_data,
	input  fhs_pkg::job_item_t    job_data,
	output logic                  report_valid,
	input  logic                  report_ready,
	output fhs_pkg::report_item_t report_data
);
	localparam int SLOT_BITS = (JOB_SLOTS > 1) ? $clog2(JOB_SLOTS) : 1;
	localparam int TB        = fhs_pkg::TIME_BITS;
	localparam int SUM_BITS  = TB + 1;
	localparam int PROD_BITS = SUM_BITS + TB;

	typedef logic [SLOT_BITS-1:0] slot_idx_t;

	logic                  policy_q;
	fhs_pkg::job_item_t    item_q;
	logic [JOB_SLOTS-1:0]  valid_q;
	slot_idx_t             idx_q;
	fhs_pkg::stamp_t       now_q;
	logic                  running_q;
	slot_idx_t             run_slot_q;
	fhs_pkg::stamp_t       run_arr_q;
	fhs_pkg::stamp_t       run_need_q;
	fhs_pkg::stamp_t       ran_q;
	fhs_pkg::stamp_t       start_q;
	logic                  best_found_q;
	slot_idx_t             best_slot_q;
	fhs_pkg::stamp_t       best_arr_q;
	fhs_pkg::stamp_t       best_need_q;
	logic                  cand_elig_s1;
	fhs_pkg::stamp_t       cand_arr_s1;
	fhs_pkg::stamp_t       cand_need_s1;
	logic [PROD_BITS-1:0]  prod_c_s1;
	logic [PROD_BITS-1:0]  prod_b_s1;
	fhs_pkg::report_item_t rpt_q;
	logic                  rpt_valid_q;

	slot_idx_t             rd_addr;
	logic [2*TB-1:0]       rd_data;
	fhs_pkg::stamp_t       rd_arr;
	fhs_pkg::stamp_t       rd_need;
	fhs_pkg::stamp_t       need_fix;
	fhs_pkg::stamp_t       wait_c;
	fhs_pkg::stamp_t       wait_b;
	logic [SUM_BITS-1:0]   sum_c;
	logic [SUM_BITS-1:0]   sum_b;
	logic [PROD_BITS-1:0]  mul_c;
	logic [PROD_BITS-1:0]  mul_b;
	logic                  ratio_gt;
	logic                  ratio_lt;
	logic                  earlier;
	logic                  better;
	logic                  take;
	logic                  dispatch;
	logic                  run_act;
	slot_idx_t             exec_slot;
	fhs_pkg::stamp_t       exec_arr;
	fhs_pkg::stamp_t       exec_need;
	fhs_pkg::stamp_t       exec_ran;
	fhs_pkg::stamp_t       exec_start;
	fhs_pkg::stamp_t       now_nx;
	fhs_pkg::stamp_t       ran_nx;
	logic                  exec_done;
	fhs_pkg::stamp_t       ta;
	logic                  out_free;
	logic                  rpt_load;
	fhs_pkg::report_item_t rpt_d;

	assign need_fix = (item_q.job_need == '0) ? fhs_pkg::stamp_t'(1) : item_q.job_need;
	assign rd_addr  = cmd.scan_cmp ? slot_idx_t'(idx_q + slot_idx_t'(1)) : idx_q;

	fhs_ram #(
		.WIDTH (2 * TB),
		.DEPTH (JOB_SLOTS)
	) u_ram (
		.clk   (clk),
		.we    (cmd.add_commit),
		.waddr (idx_q),
		.wdata ({item_q.job_arrival, need_fix}),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	assign rd_arr  = rd_data[2*TB-1:TB];
	assign rd_need = rd_data[TB-1:0];

	assign wait_c = now_q - rd_arr;
	assign wait_b = now_q - best_arr_q;
	assign sum_c  = {1'b0, wait_c} + {1'b0, rd_need};
	assign sum_b  = {1'b0, wait_b} + {1'b0, best_need_q};
	assign mul_c  = PROD_BITS'(sum_c) * PROD_BITS'(best_need_q);
	assign mul_b  = PROD_BITS'(sum_b) * PROD_BITS'(rd_need);

	assign ratio_gt = prod_c_s1 > prod_b_s1;
	assign ratio_lt = prod_c_s1 < prod_b_s1;
	assign earlier  = cand_arr_s1 < best_arr_q;
	assign better   = policy_q ? (ratio_gt || (!ratio_lt && earlier)) : earlier;
	assign take     = cand_elig_s1 && (!best_found_q || better);

	assign dispatch   = !running_q && best_found_q;
	assign run_act    = running_q || dispatch;
	assign exec_slot  = dispatch ? best_slot_q : run_slot_q;
	assign exec_arr   = dispatch ? best_arr_q  : run_arr_q;
	assign exec_need  = dispatch ? best_need_q : run_need_q;
	assign exec_ran   = dispatch ? '0          : ran_q;
	assign exec_start = dispatch ? now_q       : start_q;
	assign now_nx     = (now_q == fhs_pkg::STAMP_MAX) ? now_q : now_q + 1'b1;
	assign ran_nx     = (exec_ran == fhs_pkg::STAMP_MAX) ? exec_ran : exec_ran + 1'b1;
	assign exec_done  = run_act && (ran_nx >= exec_need);
	assign ta         = (now_nx >= exec_arr) ? now_nx - exec_arr : '0;

	assign out_free = !rpt_valid_q || report_ready;
	assign rpt_load = cmd.add_commit || cmd.add_full || cmd.exec;

	always_comb begin
		rpt_d          = '0;
		rpt_d.now_time = now_q;
		if (cmd.add_commit) begin
			rpt_d.report_kind = fhs_pkg::RPT_ACCEPTED;
			rpt_d.job_slot    = fhs_pkg::SLOT_FIELD_BITS'(idx_q);
		end else if (cmd.add_full) begin
			rpt_d.report_kind = fhs_pkg::RPT_FULL;
		end else begin
			rpt_d.report_kind = fhs_pkg::RPT_TICK;
			rpt_d.now_time    = now_nx;
			rpt_d.busy_res    = run_act;
			rpt_d.started_now = dispatch;
			rpt_d.job_done    = exec_done;
			if (run_act) begin
				rpt_d.job_slot  = fhs_pkg::SLOT_FIELD_BITS'(exec_slot);
				rpt_d.job_start = exec_start;
			end
			if (exec_done) begin
				rpt_d.turnaround = ta;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q     <= 1'b0;
			valid_q      <= '0;
			idx_q        <= '0;
			now_q        <= '0;
			running_q    <= 1'b0;
			run_slot_q   <= '0;
			best_found_q <= 1'b0;
			rpt_valid_q  <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				policy_q <= cfg_wr_data;
			end
			if (cmd.load_in) begin
				idx_q        <= '0;
				best_found_q <= 1'b0;
			end else if (cmd.find_step || cmd.scan_cmp) begin
				idx_q <= idx_q + slot_idx_t'(1);
			end
			if (cmd.scan_cmp && take) begin
				best_found_q <= 1'b1;
			end
			if (cmd.add_commit) begin
				valid_q[idx_q] <= 1'b1;
			end
			if (cmd.exec) begin
				now_q <= now_nx;
				if (run_act) begin
					running_q  <= !exec_done;
					run_slot_q <= exec_slot;
				end
				if (exec_done) begin
					valid_q[exec_slot] <= 1'b0;
				end
			end
			if (rpt_load) begin
				rpt_valid_q <= 1'b1;
			end else if (report_ready) begin
				rpt_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			item_q <= job_data;
		end
		if (cmd.scan_mul) begin
			cand_elig_s1 <= valid_q[idx_q] && (rd_arr <= now_q);
			cand_arr_s1  <= rd_arr;
			cand_need_s1 <= rd_need;
			prod_c_s1    <= mul_c;
			prod_b_s1    <= mul_b;
		end
		if (cmd.scan_cmp && take) begin
			best_slot_q <= idx_q;
			best_arr_q  <= cand_arr_s1;
			best_need_q <= cand_need_s1;
		end
		if (cmd.exec && run_act) begin
			run_arr_q  <= exec_arr;
			run_need_q <= exec_need;
			ran_q      <= ran_nx;
			start_q    <= exec_start;
		end
		if (rpt_load) begin
			rpt_q <= rpt_d;
		end
	end

	assign stat.func      = item_q.func;
	assign stat.slot_free = !valid_q[idx_q];
	assign stat.idx_last  = (idx_q == slot_idx_t'(JOB_SLOTS - 1));
	assign stat.running   = running_q;
	assign stat.out_free  = out_free;

	assign report_valid = rpt_valid_q;
	assign report_data  = rpt_q;

	a_run_valid: assert property (@(posedge clk) disable iff (!arst_n)
		running_q |-> valid_q[run_slot_q])
		else $error("fhs_dpath: running job sits in a free slot");

	a_done_frees: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.exec && exec_done) |=> !valid_q[$past(exec_slot)] && !running_q)
		else $error("fhs_dpath: completed job not released");

	a_clock_mono: assert property (@(posedge clk) disable iff (!arst_n)
		rpt_load |=> now_q >= $past(now_q))
		else $error("fhs_dpath: clock went backward");
endmodule

// ===== sv/fcfs_hrrn_job_scheduler.sv =====
// ----------------------------------------------------------------------------
// fcfs_hrrn_job_scheduler
// Non-preemptive FCFS / HRRN job scheduler over a table of job slots.
// ----------------------------------------------------------------------------
// channel     dir  handshake       item
// job_ch      in   valid/ready     func, job_arrival, job_need
// report_ch   out  valid/ready     report_kind .. turnaround
// cfg_wr_*    in   write enable    policy_mode (1 bit)
//
// Add: searches the valid bits upward from slot 0 for the lowest free slot
// (one valid bit tested per cycle).
// A tick with a job running goes straight to execution. A tick with none
// running first runs the dispatch scan (one table RAM read, then multiply and
// compare per slot). One item at a time; the next is taken while the result
// waits. A stalled result register holds the commit of the following item.
// Reset clears the valid bits at once; no clearing pass.
// ----------------------------------------------------------------------------
module fcfs_hrrn_job_scheduler #(
	parameter int JOB_SLOTS = fhs_pkg::JOB_SLOTS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	fhs_stream_if.sink          job_ch,
	fhs_stream_if.source        report_ch,
	input  logic                cfg_wr_en,
	input  logic                cfg_wr_data
);
	fhs_pkg::fhs_cmd_t  cmd;
	fhs_pkg::fhs_stat_t stat;
	logic               job_ready;

	fhs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (job_ch.valid),
		.job_ready (job_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	fhs_dpath #(
		.JOB_SLOTS (JOB_SLOTS)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.job_data     (job_ch.data),
		.report_valid (report_ch.valid),
		.report_ready (report_ch.ready),
		.report_data  (report_ch.data)
	);

	assign job_ch.ready = job_ready;
endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Testbench for the FCFS / HRRN job scheduler. A class keeps its own copy of
// the job table, the run state and the clock, works out the report of every
// accepted item and compares each report field by field. Directed items come
// first. Random traffic follows under three idling patterns and both
// policies.
// ----------------------------------------------------------------------------
module tb;

	class sched_scoreboard;
		logic                  hrrn;
		logic                  used    [fhs_pkg::JOB_SLOTS_DEF];
		fhs_pkg::stamp_t       arrival [fhs_pkg::JOB_SLOTS_DEF];
		fhs_pkg::stamp_t       need    [fhs_pkg::JOB_SLOTS_DEF];
		fhs_pkg::stamp_t       ran     [fhs_pkg::JOB_SLOTS_DEF];
		fhs_pkg::stamp_t       start   [fhs_pkg::JOB_SLOTS_DEF];
		logic                  busy;
		int                    run_slot;
		fhs_pkg::stamp_t       now;
		fhs_pkg::report_item_t due_reports [$];
		int                    errors;

		function new();
			hrrn = 1'b0;
			busy = 1'b0;
			run_slot = 0;
			now = '0;
			errors = 0;
			foreach (used[i]) begin
				used[i] = 1'b0;
				arrival[i] = '0;
				need[i] = '0;
				ran[i] = '0;
				start[i] = '0;
			end
		endfunction

		function int free_slots();
			int n;
			n = 0;
			foreach (used[i])
				if (!used[i])
					n++;
			return n;
		endfunction

		function bit ratio_above(int c, int b);
			logic [16:0] rc;
			logic [16:0] rb;
			logic [33:0] lhs;
			logic [33:0] rhs;
			rc = 17'(now - arrival[c]) + 17'(need[c]);
			rb = 17'(now - arrival[b]) + 17'(need[b]);
			lhs = 34'(rc) * 34'(need[b]);
			rhs = 34'(rb) * 34'(need[c]);
			return lhs > rhs;
		endfunction

		function int choose_job();
			int  best;
			bit  better;
			best = -1;
			for (int i = 0; i < fhs_pkg::JOB_SLOTS_DEF; i++) begin
				if (!used[i] || arrival[i] > now)
					continue;
				if (best < 0) begin
					best = i;
					continue;
				end
				if (hrrn && ratio_above(i, best))
					better = 1'b1;
				else if (hrrn && ratio_above(best, i))
					better = 1'b0;
				else
					better = arrival[i] < arrival[best];
				if (better)
					best = i;
			end
			return best;
		endfunction

		function fhs_pkg::report_item_t advance(fhs_pkg::job_item_t it);
			fhs_pkg::report_item_t r;
			int                    slot;
			r = '0;
			slot = -1;
			if (it.func == fhs_pkg::FUNC_ADD) begin
				r.now_time = now;
				for (int i = 0; i < fhs_pkg::JOB_SLOTS_DEF; i++)
					if (!used[i] && slot < 0)
						slot = i;
				if (slot < 0) begin
					r.report_kind = fhs_pkg::RPT_FULL;
					return r;
				end
				used[slot] = 1'b1;
				arrival[slot] = it.job_arrival;
				need[slot] = (it.job_need == '0) ? fhs_pkg::stamp_t'(1) : it.job_need;
				ran[slot] = '0;
				start[slot] = '0;
				r.report_kind = fhs_pkg::RPT_ACCEPTED;
				r.job_slot = 4'(slot);
				return r;
			end
			r.report_kind = fhs_pkg::RPT_TICK;
			if (!busy) begin
				slot = choose_job();
				if (slot >= 0) begin
					busy = 1'b1;
					run_slot = slot;
					start[slot] = now;
					r.started_now = 1'b1;
				end
			end
			if (now != fhs_pkg::STAMP_MAX)
				now++;
			r.now_time = now;
			if (busy) begin
				r.job_slot = 4'(run_slot);
				r.busy_res = 1'b1;
				r.job_start = start[run_slot];
				if (ran[run_slot] != fhs_pkg::STAMP_MAX)
					ran[run_slot]++;
				if (ran[run_slot] >= need[run_slot]) begin
					r.job_done = 1'b1;
					if (now >= arrival[run_slot])
						r.turnaround = now - arrival[run_slot];
					used[run_slot] = 1'b0;
					busy = 1'b0;
				end
			end
			return r;
		endfunction

		function void note_job(fhs_pkg::job_item_t it);
			due_reports.push_back(advance(it));
		endfunction

		function void match(string field, int unsigned want, int unsigned got);
			if (want != got) begin
				$error("%s: expected %0d, got %0d", field, want, got);
				errors++;
			end
		endfunction

		function void check_report(fhs_pkg::report_item_t got);
			fhs_pkg::report_item_t want;
			if (due_reports.size() == 0) begin
				$error("report with no item pending: kind %0d slot %0d",
					got.report_kind, got.job_slot);
				errors++;
				return;
			end
			want = due_reports.pop_front();
			match("report_kind", want.report_kind, got.report_kind);
			match("job_slot", want.job_slot, got.job_slot);
			match("busy_res", want.busy_res, got.busy_res);
			match("now_time", want.now_time, got.now_time);
			match("started_now", want.started_now, got.started_now);
			match("job_start", want.job_start, got.job_start);
			match("job_done", want.job_done, got.job_done);
			match("turnaround", want.turnaround, got.turnaround);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en;
	logic cfg_wr_data;
	int   send_idle = 23;
	int   recv_idle = 77;
	bit   calm = 1'b0;

	sched_scoreboard sb = new();

	fhs_stream_if #(.T(fhs_pkg::job_item_t))    job_ch ();
	fhs_stream_if #(.T(fhs_pkg::report_item_t)) report_ch ();

	fcfs_hrrn_job_scheduler #(
		.JOB_SLOTS(fhs_pkg::JOB_SLOTS_DEF)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.job_ch     (job_ch),
		.report_ch  (report_ch),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && report_ch.valid && report_ch.ready)
			sb.check_report(report_ch.data);
		report_ch.ready <= calm || ($urandom_range(0, 99) >= recv_idle);
	end

	initial begin
		#30ms;
		$display("RESULT: ERROR");
		$finish;
	end

	function automatic fhs_pkg::job_item_t job_item(logic f, fhs_pkg::stamp_t a,
		fhs_pkg::stamp_t n);
		fhs_pkg::job_item_t it;
		it.func = f;
		it.job_arrival = a;
		it.job_need = n;
		return it;
	endfunction

	function automatic fhs_pkg::job_item_t random_job(int add_pct);
		fhs_pkg::job_item_t it;
		int                 back;
		int                 roll;
		it = job_item(fhs_pkg::FUNC_TICK, fhs_pkg::stamp_t'($urandom),
			fhs_pkg::stamp_t'($urandom));
		if ($urandom_range(0, 99) >= add_pct)
			return it;
		it.func = fhs_pkg::FUNC_ADD;
		roll = $urandom_range(0, 99);
		if (roll < 80) begin
			back = $urandom_range(0, 40);
			it.job_arrival = (sb.now > back) ? fhs_pkg::stamp_t'(sb.now - back) : '0;
		end else if (roll < 95) begin
			it.job_arrival = (fhs_pkg::STAMP_MAX - sb.now > 8) ?
				fhs_pkg::stamp_t'(sb.now + $urandom_range(1, 8)) : fhs_pkg::STAMP_MAX;
		end else begin
			it.job_arrival = fhs_pkg::stamp_t'($urandom_range(0, sb.now));
		end
		roll = $urandom_range(0, 99);
		if (roll < 70)
			it.job_need = fhs_pkg::stamp_t'($urandom_range(1, 6));
		else if (roll < 90)
			it.job_need = fhs_pkg::stamp_t'($urandom_range(7, 40));
		else if (roll < 95)
			it.job_need = '0;
		else
			it.job_need = fhs_pkg::stamp_t'($urandom_range(41, 400));
		return it;
	endfunction

	task automatic send(fhs_pkg::job_item_t it);
		while (!calm && $urandom_range(0, 99) < send_idle) begin
			job_ch.valid <= 1'b0;
			@(posedge clk);
		end
		job_ch.valid <= 1'b1;
		job_ch.data <= it;
		do
			@(posedge clk);
		while (!job_ch.ready);
		sb.note_job(it);
	endtask

	task automatic drain();
		job_ch.valid <= 1'b0;
		while (sb.due_reports.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_policy(logic mode);
		drain();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= mode;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		sb.hrrn = mode;
	endtask

	task automatic run_random(int count);
		int add_pct;
		add_pct = 30;
		for (int i = 0; i < count; i++) begin
			if (i % 60 == 0)
				calm = ($urandom_range(0, 4) == 0);
			if (i % 100 == 0)
				add_pct = $urandom_range(0, 1) ? 40 : 15;
			send(random_job(add_pct));
		end
		calm = 1'b0;
	endtask

	initial begin
		job_ch.valid <= 1'b0;
		job_ch.data <= '0;
		cfg_wr_en <= 1'b0;
		cfg_wr_data <= 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_policy(1'b0);
		send(job_item(fhs_pkg::FUNC_TICK, '0, '0));
		send(job_item(fhs_pkg::FUNC_ADD, '0, '0));
		send(job_item(fhs_pkg::FUNC_ADD, fhs_pkg::STAMP_MAX, 16'd3));
		send(job_item(fhs_pkg::FUNC_ADD, 16'd1, 16'd2));
		send(job_item(fhs_pkg::FUNC_ADD, '0, 16'd5));
		repeat (3) send(job_item(fhs_pkg::FUNC_TICK, fhs_pkg::STAMP_MAX, fhs_pkg::STAMP_MAX));
		write_policy(1'b1);
		send(job_item(fhs_pkg::FUNC_ADD, 16'd1, 16'd1));
		send(job_item(fhs_pkg::FUNC_ADD, 16'd2, 16'd7));
		repeat (3) send(job_item(fhs_pkg::FUNC_TICK, '0, '0));
		while (sb.free_slots() > 0)
			send(job_item(fhs_pkg::FUNC_ADD, sb.now,
				fhs_pkg::stamp_t'($urandom_range(1, 3))));
		send(job_item(fhs_pkg::FUNC_ADD, sb.now, 16'd1));

		run_random(650);

		write_policy(1'b0);
		send_idle = 77;
		recv_idle = 23;
		run_random(650);

		write_policy(1'b1);
		send_idle = 0;
		recv_idle = 0;
		run_random(650);

		drain();
		repeat (2 * fhs_pkg::JOB_SLOTS_DEF + 8) @(posedge clk);
		if (sb.errors == 0 && sb.due_reports.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule

// ===== files.f =====
sv/fhs_pkg.sv
sv/fhs_stream_if.sv
sv/fhs_ram.sv
sv/fhs_ctrl.sv
sv/fhs_dpath.sv
sv/fcfs_hrrn_job_scheduler.sv
test/tb.sv
